// ===== design/cau_pkg.sv =====
// shared constants and types for the complex arithmetic unit
`timescale 1ns / 1ps

package cau_pkg;

    localparam int CAU_WORD_BITS = 32;
    localparam int CAU_FRAC_BITS = 16;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SUB   = 3'd1;
    localparam logic [2:0] MODE_MUL   = 3'd2;
    localparam logic [2:0] MODE_DIV   = 3'd3;
    localparam logic [2:0] MODE_SCALE = 3'd4;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_DZ  = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    typedef struct packed {
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } cau_flags_t;

endpackage

// ===== design/cau_mult.sv =====
// operand select and product stage
`timescale 1ns / 1ps

module cau_mult
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [2:0]                    mode,
    input  logic signed [WORD_BITS-1:0]   a_re,
    input  logic signed [WORD_BITS-1:0]   a_im,
    input  logic signed [WORD_BITS-1:0]   b_re,
    input  logic signed [WORD_BITS-1:0]   b_im,
    input  logic signed [WORD_BITS-1:0]   scalar,
    output logic                          valid_reg,
    output logic [2:0]                    mode_reg,
    output logic signed [2*WORD_BITS-1:0] p0_reg,
    output logic signed [2*WORD_BITS-1:0] p1_reg,
    output logic signed [2*WORD_BITS-1:0] p2_reg,
    output logic signed [2*WORD_BITS-1:0] p3_reg,
    output logic signed [2*WORD_BITS-1:0] sq0_reg,
    output logic signed [2*WORD_BITS-1:0] sq1_reg,
    output logic signed [WORD_BITS:0]     sum_re_reg,
    output logic signed [WORD_BITS:0]     sum_im_reg
);

    localparam int W = WORD_BITS;

    logic signed [W-1:0]   y0, x2, y2;
    logic signed [W:0]     ar_x, ai_x, br_x, bi_x;
    logic signed [W:0]     sum_re_next, sum_im_next;

    always_comb
    begin
        y0 = (mode == MODE_SCALE) ? scalar : b_re;
        x2 = (mode == MODE_SCALE) ? a_im : a_re;
        y2 = (mode == MODE_SCALE) ? scalar : b_im;
        ar_x = {a_re[W-1], a_re};
        ai_x = {a_im[W-1], a_im};
        br_x = {b_re[W-1], b_re};
        bi_x = {b_im[W-1], b_im};
        if (mode == MODE_SUB)
        begin
            sum_re_next = ar_x - br_x;
            sum_im_next = ai_x - bi_x;
        end
        else
        begin
            sum_re_next = ar_x + br_x;
            sum_im_next = ai_x + bi_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg   <= mode;
            p0_reg     <= a_re * y0;
            p1_reg     <= a_im * b_im;
            p2_reg     <= x2 * y2;
            p3_reg     <= a_im * b_re;
            sq0_reg    <= b_re * b_re;
            sq1_reg    <= b_im * b_im;
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
        end
    end

endmodule

// ===== design/cau_comb.sv =====
// term combine, sign-magnitude split and product rounding, two stages
`timescale 1ns / 1ps

module cau_comb
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0]                          mode,
    input  logic signed [2*WORD_BITS-1:0]       p0,
    input  logic signed [2*WORD_BITS-1:0]       p1,
    input  logic signed [2*WORD_BITS-1:0]       p2,
    input  logic signed [2*WORD_BITS-1:0]       p3,
    input  logic signed [2*WORD_BITS-1:0]       sq0,
    input  logic signed [2*WORD_BITS-1:0]       sq1,
    input  logic signed [WORD_BITS:0]           sum_re,
    input  logic signed [WORD_BITS:0]           sum_im,
    output logic                                valid_reg,
    output cau_flags_t                          flags_reg,
    output logic [2*WORD_BITS+FRAC_BITS:0]      num_re_reg,
    output logic [2*WORD_BITS+FRAC_BITS:0]      num_im_reg,
    output logic [2*WORD_BITS:0]                den_reg
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2*W + 1;
    localparam int NW = MW + FRAC_BITS;
    localparam logic [MW-1:0] HALF = (MW'(1) << FRAC_BITS) >> 1;

    logic signed [MW-1:0] p0x, p1x, p2x, p3x;
    logic signed [MW-1:0] t_re_next, t_im_next;
    logic [MW-1:0]        den_next;

    logic                 va_reg;
    logic [2:0]           mode_a_reg;
    logic signed [MW-1:0] t_re_reg, t_im_reg;
    logic [MW-1:0]        den_a_reg;

    logic [MW-1:0]        mag_re, mag_im;
    logic [NW-1:0]        num_re_next, num_im_next;
    cau_flags_t           flags_next;

    always_comb
    begin
        p0x = {p0[2*W-1], p0};
        p1x = {p1[2*W-1], p1};
        p2x = {p2[2*W-1], p2};
        p3x = {p3[2*W-1], p3};
        den_next = {1'b0, sq0} + {1'b0, sq1};
        case (mode)
            MODE_ADD, MODE_SUB:
            begin
                t_re_next = {{(W){sum_re[W]}}, sum_re};
                t_im_next = {{(W){sum_im[W]}}, sum_im};
            end
            MODE_MUL:
            begin
                t_re_next = p0x - p1x;
                t_im_next = p2x + p3x;
            end
            MODE_DIV:
            begin
                t_re_next = p0x + p1x;
                t_im_next = p3x - p2x;
            end
            MODE_SCALE:
            begin
                t_re_next = p0x;
                t_im_next = p2x;
            end
            default:
            begin
                t_re_next = '0;
                t_im_next = '0;
            end
        endcase
    end

    always_comb
    begin
        mag_re = t_re_reg[MW-1] ? MW'(-t_re_reg) : MW'(t_re_reg);
        mag_im = t_im_reg[MW-1] ? MW'(-t_im_reg) : MW'(t_im_reg);
        flags_next.is_div = (mode_a_reg == MODE_DIV);
        flags_next.dz     = (mode_a_reg == MODE_DIV) && (den_a_reg == '0);
        flags_next.neg_re = t_re_reg[MW-1];
        flags_next.neg_im = t_im_reg[MW-1];
        flags_next.ovf_re = 1'b0;
        flags_next.ovf_im = 1'b0;
        case (mode_a_reg)
            MODE_MUL, MODE_SCALE:
            begin
                num_re_next = NW'((mag_re + HALF) >> FRAC_BITS);
                num_im_next = NW'((mag_im + HALF) >> FRAC_BITS);
            end
            MODE_DIV:
            begin
                num_re_next = NW'(mag_re) << FRAC_BITS;
                num_im_next = NW'(mag_im) << FRAC_BITS;
            end
            default:
            begin
                num_re_next = NW'(mag_re);
                num_im_next = NW'(mag_im);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg    <= in_valid;
            valid_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_a_reg <= mode;
            t_re_reg   <= t_re_next;
            t_im_reg   <= t_im_next;
            den_a_reg  <= den_next;
            flags_reg  <= flags_next;
            num_re_reg <= num_re_next;
            num_im_reg <= num_im_next;
            den_reg    <= den_a_reg;
        end
    end

endmodule

// ===== design/cau_div.sv =====
// restoring divider, one quotient bit per stage for both components
`timescale 1ns / 1ps

module cau_div
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  cau_flags_t                          flags,
    input  logic [2*WORD_BITS+FRAC_BITS:0]      num_re,
    input  logic [2*WORD_BITS+FRAC_BITS:0]      num_im,
    input  logic [2*WORD_BITS:0]                den,
    output logic                                valid_out,
    output cau_flags_t                          flags_out,
    output logic [2*WORD_BITS+FRAC_BITS:0]      rem_re_out,
    output logic [2*WORD_BITS+FRAC_BITS:0]      rem_im_out,
    output logic [WORD_BITS:0]                  q_re_out,
    output logic [WORD_BITS:0]                  q_im_out,
    output logic [2*WORD_BITS:0]                den_out
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2*W + 1;
    localparam int NW = MW + FRAC_BITS;
    localparam int CW = NW + W + 2;

    logic          v_reg  [0:W];
    cau_flags_t    f_reg  [0:W];
    logic [NW-1:0] rr_reg [0:W];
    logic [NW-1:0] ri_reg [0:W];
    logic [W:0]    qr_reg [0:W];
    logic [W:0]    qi_reg [0:W];
    logic [MW-1:0] d_reg  [0:W];

    for (genvar k = 0; k <= W; k++)
    begin : g_step
        localparam int SH = W - k;

        logic          v_in;
        cau_flags_t    f_in;
        logic [NW-1:0] rr_in, ri_in;
        logic [W:0]    qr_in, qi_in;
        logic [MW-1:0] d_in;
        logic [CW-1:0] dsh;
        logic          take_re, take_im;
        cau_flags_t    f_next;
        logic [NW-1:0] rr_next, ri_next;
        logic [W:0]    qr_next, qi_next;

        if (k == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign f_in  = flags;
            assign rr_in = num_re;
            assign ri_in = num_im;
            assign qr_in = '0;
            assign qi_in = '0;
            assign d_in  = den;
        end
        else
        begin : g_next
            assign v_in  = v_reg[k-1];
            assign f_in  = f_reg[k-1];
            assign rr_in = rr_reg[k-1];
            assign ri_in = ri_reg[k-1];
            assign qr_in = qr_reg[k-1];
            assign qi_in = qi_reg[k-1];
            assign d_in  = d_reg[k-1];
        end

        always_comb
        begin
            dsh     = CW'(d_in) << SH;
            take_re = f_in.is_div && (CW'(rr_in) >= dsh);
            take_im = f_in.is_div && (CW'(ri_in) >= dsh);
            rr_next = take_re ? NW'(CW'(rr_in) - dsh) : rr_in;
            ri_next = take_im ? NW'(CW'(ri_in) - dsh) : ri_in;
            qr_next = qr_in;
            qi_next = qi_in;
            qr_next[SH] = take_re;
            qi_next[SH] = take_im;
            f_next = f_in;
            if (k == 0)
            begin
                f_next.ovf_re = f_in.is_div && (CW'(rr_in) >= (dsh << 1));
                f_next.ovf_im = f_in.is_div && (CW'(ri_in) >= (dsh << 1));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg[k]  <= f_next;
                rr_reg[k] <= rr_next;
                ri_reg[k] <= ri_next;
                qr_reg[k] <= qr_next;
                qi_reg[k] <= qi_next;
                d_reg[k]  <= d_in;
            end
        end
    end

    assign valid_out  = v_reg[W];
    assign flags_out  = f_reg[W];
    assign rem_re_out = rr_reg[W];
    assign rem_im_out = ri_reg[W];
    assign q_re_out   = qr_reg[W];
    assign q_im_out   = qi_reg[W];
    assign den_out    = d_reg[W];

endmodule

// ===== design/cau_out.sv =====
// quotient rounding, saturation, status and output register
`timescale 1ns / 1ps

module cau_out
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  cau_flags_t                      flags,
    input  logic [2*WORD_BITS+FRAC_BITS:0]  rem_re,
    input  logic [2*WORD_BITS+FRAC_BITS:0]  rem_im,
    input  logic [WORD_BITS:0]              q_re,
    input  logic [WORD_BITS:0]              q_im,
    input  logic [2*WORD_BITS:0]            den,
    output logic                            valid_reg,
    output logic signed [WORD_BITS-1:0]     res_re_reg,
    output logic signed [WORD_BITS-1:0]     res_im_reg,
    output logic [1:0]                      status_reg
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2*W + 1;
    localparam int NW = MW + FRAC_BITS;
    localparam int XW = NW + 1;
    localparam logic [XW-1:0] LIM_POS = (XW'(1) << (W-1)) - XW'(1);

    logic [XW-1:0]      mag_re, mag_im, lim_re, lim_im, val_re, val_im;
    logic               sat_re, sat_im;
    logic [W-1:0]       res_re_next, res_im_next;
    logic [1:0]         status_next;

    always_comb
    begin
        if (flags.is_div)
        begin
            mag_re = XW'(q_re) + XW'((XW'(rem_re) << 1) >= XW'(den));
            mag_im = XW'(q_im) + XW'((XW'(rem_im) << 1) >= XW'(den));
        end
        else
        begin
            mag_re = XW'(rem_re);
            mag_im = XW'(rem_im);
        end
        lim_re = flags.neg_re ? LIM_POS + XW'(1) : LIM_POS;
        lim_im = flags.neg_im ? LIM_POS + XW'(1) : LIM_POS;
        sat_re = flags.ovf_re || (mag_re > lim_re);
        sat_im = flags.ovf_im || (mag_im > lim_im);
        val_re = sat_re ? lim_re : mag_re;
        val_im = sat_im ? lim_im : mag_im;
        res_re_next = flags.neg_re ? W'(-val_re) : W'(val_re);
        res_im_next = flags.neg_im ? W'(-val_im) : W'(val_im);
        if (flags.dz)
        begin
            res_re_next = '0;
            res_im_next = '0;
            status_next = STAT_DZ;
        end
        else if (sat_re || sat_im)
        begin
            status_next = STAT_SAT;
        end
        else
        begin
            status_next = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== design/complex_arithmetic_unit.sv =====
// complex arithmetic unit top level
`timescale 1ns / 1ps

// Fully pipelined: one beat is accepted every cycle while the output side
// takes results, and each result passes through one multiplier stage,
// two combine/round stages, one restoring-divider stage per quotient bit
// (WORD_BITS + 1 of them, passed through by the non-divide modes) and the
// saturating output register. When the output beat is held, the whole
// pipeline holds and s_tready drops.

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // a_re, a_im, b_re, b_im, scalar
    input  logic [((5*WORD_BITS+7)/8)*8-1:0]      s_tdata,
    // mode
    input  logic [2:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // res_re, res_im
    output logic [((2*WORD_BITS+7)/8)*8-1:0]      m_tdata,
    // status
    output logic [1:0]                            m_tuser
);

    localparam int W     = WORD_BITS;
    localparam int OUT_W = ((2*W+7)/8)*8;
    localparam int MW    = 2*W + 1;
    localparam int NW    = MW + FRAC_BITS;

    logic en;

    logic                 v1;
    logic [2:0]           mode1;
    logic signed [2*W-1:0] p0, p1, p2, p3, sq0, sq1;
    logic signed [W:0]    sum_re, sum_im;

    logic                 v2;
    cau_flags_t           f2;
    logic [NW-1:0]        num_re, num_im;
    logic [MW-1:0]        den2;

    logic                 v3;
    cau_flags_t           f3;
    logic [NW-1:0]        rem_re, rem_im;
    logic [W:0]           q_re, q_im;
    logic [MW-1:0]        den3;

    logic signed [W-1:0]  res_re, res_im;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cau_mult #(.WORD_BITS(W)) u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .mode       (s_tuser),
        .a_re       (s_tdata[W-1:0]),
        .a_im       (s_tdata[2*W-1:W]),
        .b_re       (s_tdata[3*W-1:2*W]),
        .b_im       (s_tdata[4*W-1:3*W]),
        .scalar     (s_tdata[5*W-1:4*W]),
        .valid_reg  (v1),
        .mode_reg   (mode1),
        .p0_reg     (p0),
        .p1_reg     (p1),
        .p2_reg     (p2),
        .p3_reg     (p3),
        .sq0_reg    (sq0),
        .sq1_reg    (sq1),
        .sum_re_reg (sum_re),
        .sum_im_reg (sum_im)
    );

    cau_comb #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_comb (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (v1),
        .mode       (mode1),
        .p0         (p0),
        .p1         (p1),
        .p2         (p2),
        .p3         (p3),
        .sq0        (sq0),
        .sq1        (sq1),
        .sum_re     (sum_re),
        .sum_im     (sum_im),
        .valid_reg  (v2),
        .flags_reg  (f2),
        .num_re_reg (num_re),
        .num_im_reg (num_im),
        .den_reg    (den2)
    );

    cau_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (v2),
        .flags      (f2),
        .num_re     (num_re),
        .num_im     (num_im),
        .den        (den2),
        .valid_out  (v3),
        .flags_out  (f3),
        .rem_re_out (rem_re),
        .rem_im_out (rem_im),
        .q_re_out   (q_re),
        .q_im_out   (q_im),
        .den_out    (den3)
    );

    cau_out #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (v3),
        .flags      (f3),
        .rem_re     (rem_re),
        .rem_im     (rem_im),
        .q_re       (q_re),
        .q_im       (q_im),
        .den        (den3),
        .valid_reg  (m_tvalid),
        .res_re_reg (res_re),
        .res_im_reg (res_im),
        .status_reg (m_tuser)
    );

    assign m_tdata = OUT_W'({res_im, res_re});

endmodule
